// ===== rtl/class_wise_box_suppression_unit_assert.svh =====
// Assertion macros for the box suppression unit.
// Included by RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef CLASS_WISE_BOX_SUPPRESSION_UNIT_ASSERT_SVH
`define CLASS_WISE_BOX_SUPPRESSION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CBS_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define CBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CBS_ASSERT_ALWAYS(lbl, expr)
`define CBS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/cbs_pkg.sv =====
// Shared constants, codes and types of the box suppression unit.
// No dependencies.
`timescale 1ns / 1ps
package cbs_pkg;
  localparam int MAX_BOXES = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int COORD_W   = 16;
  localparam int SCORE_W   = 16;
  localparam int CLASS_W   = 6;
  localparam int NUM_CLASSES = 64;
  localparam int LIMIT_W   = 7;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_CONF_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IOU_THR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DET  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLS_MASK = 2'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef struct packed {
    logic [SCORE_W-1:0]     conf_thr;
    logic [SCORE_W-1:0]     iou_thr;
    logic [LIMIT_W-1:0]     max_det;
    logic [NUM_CLASSES-1:0] class_mask;
  } cfg_t;

  typedef struct packed {
    logic               is_end;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [SCORE_W-1:0] score;
    logic [CLASS_W-1:0] cls;
  } q_item_t;

  typedef struct packed {
    logic               valid_res;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [SCORE_W-1:0] score;
    logic [CLASS_W-1:0] cls;
    logic               last;
    logic               ovf;
  } res_t;
endpackage

// ===== rtl/cbs_front.sv =====
// Front end: configuration registers and the input filter (threshold, class mask).
// Depends on cbs_pkg.
`timescale 1ns / 1ps
module cbs_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [cbs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cbs_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_cmd,
  input  logic [cbs_pkg::COORD_W-1:0]          in_box_x,
  input  logic [cbs_pkg::COORD_W-1:0]          in_box_y,
  input  logic [cbs_pkg::COORD_W-1:0]          in_box_w,
  input  logic [cbs_pkg::COORD_W-1:0]          in_box_h,
  input  logic [cbs_pkg::SCORE_W-1:0]          in_confidence,
  input  logic [cbs_pkg::CLASS_W-1:0]          in_class_id,
  input  logic                                 q_full,
  output logic                                 q_push,
  output cbs_pkg::q_item_t                     q_item,
  output cbs_pkg::cfg_t                        cfg
);
  cbs_pkg::cfg_t cfg_r;
  logic          keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.conf_thr   <= 16'd32768;
      cfg_r.iou_thr    <= 16'd26214;
      cfg_r.max_det    <= 7'd64;
      cfg_r.class_mask <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbs_pkg::CFG_CONF_THR: cfg_r.conf_thr   <= cfg_wdata[cbs_pkg::SCORE_W-1:0];
        cbs_pkg::CFG_IOU_THR:  cfg_r.iou_thr    <= cfg_wdata[cbs_pkg::SCORE_W-1:0];
        cbs_pkg::CFG_MAX_DET:  cfg_r.max_det    <= cfg_wdata[cbs_pkg::LIMIT_W-1:0];
        cbs_pkg::CFG_CLS_MASK: cfg_r.class_mask <= cfg_wdata[cbs_pkg::NUM_CLASSES-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

  // filtered loads are consumed here and never reach the queue
  assign keep = (in_cmd == cbs_pkg::CMD_END) ||
                ((in_confidence >= cfg_r.conf_thr) && cfg_r.class_mask[in_class_id]);
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && keep;

  always_comb begin
    q_item.is_end = (in_cmd == cbs_pkg::CMD_END);
    q_item.x      = in_box_x;
    q_item.y      = in_box_y;
    q_item.w      = in_box_w;
    q_item.h      = in_box_h;
    q_item.score  = in_confidence;
    q_item.cls    = in_class_id;
  end
endmodule

// ===== rtl/cbs_fifo.sv =====
// Short queue of filtered items between front and back.
// Depends on cbs_pkg.
`timescale 1ns / 1ps
module cbs_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cbs_pkg::q_item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output cbs_pkg::q_item_t pop_item
);
  cbs_pkg::q_item_t                   slot_r [cbs_pkg::FIFO_DEPTH];
  logic [cbs_pkg::FIFO_PTR_W-1:0]     wptr_r, rptr_r;
  logic [cbs_pkg::FIFO_CNT_W-1:0]     cnt_r;
  logic                               do_push, do_pop;

  assign full     = (cnt_r == cbs_pkg::FIFO_CNT_W'(cbs_pkg::FIFO_DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_item = slot_r[rptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)  rptr_r <= rptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (!do_push && do_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wptr_r] <= push_item;
  end
endmodule

// ===== rtl/cbs_back.sv =====
// Back end: box store, max-score selection, overlap pipeline and result output.
// Depends on cbs_pkg and class_wise_box_suppression_unit_assert.svh.
`timescale 1ns / 1ps
`include "class_wise_box_suppression_unit_assert.svh"
module cbs_back (
  input  logic             clk,
  input  logic             rst_n,
  input  cbs_pkg::cfg_t    cfg,
  input  logic             q_valid,
  input  cbs_pkg::q_item_t q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output cbs_pkg::res_t    out_res
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FIND = 3'd1;
  localparam logic [2:0] ST_EMIT = 3'd2;
  localparam logic [2:0] ST_SUPP = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam int CW = cbs_pkg::COORD_W;
  localparam int AW = 2 * CW;

  logic [2*CW+2*CW-1:0]                          geom_mem [cbs_pkg::MAX_BOXES];
  logic [cbs_pkg::SCORE_W+cbs_pkg::CLASS_W-1:0]  sc_mem   [cbs_pkg::MAX_BOXES];

  logic [2:0]                     state_r;
  logic [cbs_pkg::CNT_W-1:0]      cnt_r, n_r, issue_r, emitted_r;
  logic                           ovf_r;
  logic [cbs_pkg::MAX_BOXES-1:0]  done_r;
  logic                           out_valid_r, pend_v_r, best_v_r;
  cbs_pkg::res_t                  out_r, pend_r;

  // read stage
  logic                           rd_v_r;
  logic [cbs_pkg::IDX_W-1:0]      rd_idx_r;
  logic [CW-1:0]                  rx, ry, rw, rh;
  logic [cbs_pkg::SCORE_W-1:0]    rscore;
  logic [cbs_pkg::CLASS_W-1:0]    rcls;
  logic [4*CW-1:0]                rd_geom_r;
  logic [cbs_pkg::SCORE_W+cbs_pkg::CLASS_W-1:0] rd_sc_r;
  logic [AW-1:0]                  rd_area;

  // selected box
  logic [cbs_pkg::IDX_W-1:0]      best_idx_r;
  logic [CW-1:0]                  bx_r, by_r, bw_r, bh_r;
  logic [cbs_pkg::SCORE_W-1:0]    bscore_r;
  logic [cbs_pkg::CLASS_W-1:0]    bcls_r;
  logic [AW-1:0]                  barea_r;

  // overlap pipeline
  logic                           a_v_r, b_v_r, c_v_r, d_v_r;
  logic [cbs_pkg::IDX_W-1:0]      a_idx_r, b_idx_r, c_idx_r, d_idx_r;
  logic [CW-1:0]                  iw_r, ih_r;
  logic [AW-1:0]                  a_area_r, b_area_r;
  logic [AW-1:0]                  inter_r, c_inter_r;
  logic [AW:0]                    uni_r;
  logic [AW+cbs_pkg::SCORE_W:0]   rhs_r;
  logic [AW+cbs_pkg::SCORE_W-1:0] lhs_r;
  logic                           uni_nz_r;

  logic [CW:0]                    x1, y1, ax2, bx2, ay2, by2, x2, y2;
  logic [CW-1:0]                  iw, ih;
  logic                           out_free, scan, issue, drained, find_hit, d_hit;
  logic [cbs_pkg::CNT_W-1:0]      limit, emitted_inc;

  assign {rx, ry, rw, rh} = rd_geom_r;
  assign {rscore, rcls}   = rd_sc_r;
  assign rd_area          = rw * rh;

  assign out_free    = !out_valid_r || out_ready;
  assign q_pop       = (state_r == ST_IDLE) && q_valid;
  assign scan        = (state_r == ST_FIND) || (state_r == ST_SUPP);
  assign issue       = scan && (issue_r < n_r);
  assign drained     = (issue_r == n_r) && !rd_v_r && !a_v_r && !b_v_r && !c_v_r && !d_v_r;
  assign find_hit    = (state_r == ST_FIND) && rd_v_r && !done_r[rd_idx_r] &&
                       (!best_v_r || (rscore > bscore_r));
  assign limit       = ((cfg.max_det == '0) || (cfg.max_det > n_r)) ? n_r : cfg.max_det;
  assign emitted_inc = emitted_r + 1'b1;
  assign d_hit       = d_v_r && uni_nz_r && ({1'b0, lhs_r} > rhs_r);

  // intersection extent; right and bottom edges one bit wider
  always_comb begin
    x1  = (bx_r > rx) ? {1'b0, bx_r} : {1'b0, rx};
    y1  = (by_r > ry) ? {1'b0, by_r} : {1'b0, ry};
    ax2 = {1'b0, bx_r} + {1'b0, bw_r};
    bx2 = {1'b0, rx} + {1'b0, rw};
    ay2 = {1'b0, by_r} + {1'b0, bh_r};
    by2 = {1'b0, ry} + {1'b0, rh};
    x2  = (ax2 < bx2) ? ax2 : bx2;
    y2  = (ay2 < by2) ? ay2 : by2;
    iw  = (x2 > x1) ? CW'(x2 - x1) : '0;
    ih  = (y2 > y1) ? CW'(y2 - y1) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      n_r         <= '0;
      issue_r     <= '0;
      emitted_r   <= '0;
      ovf_r       <= 1'b0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      best_v_r    <= 1'b0;
      rd_v_r      <= 1'b0;
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      d_v_r       <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      rd_v_r <= issue;
      a_v_r  <= (state_r == ST_SUPP) && rd_v_r && !done_r[rd_idx_r] && (rcls == bcls_r);
      b_v_r  <= a_v_r;
      c_v_r  <= b_v_r;
      d_v_r  <= c_v_r;
      if (d_hit)    done_r[d_idx_r] <= 1'b1;
      if (issue)    issue_r <= issue_r + 1'b1;
      if (find_hit) best_v_r <= 1'b1;
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_item.is_end) begin
              n_r       <= cnt_r;
              done_r    <= '0;
              emitted_r <= '0;
              pend_v_r  <= 1'b0;
              issue_r   <= '0;
              best_v_r  <= 1'b0;
              state_r   <= (cnt_r == '0) ? ST_FIN : ST_FIND;
            end else if (cnt_r == cbs_pkg::CNT_W'(cbs_pkg::MAX_BOXES)) begin
              ovf_r <= 1'b1;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        ST_FIND: begin
          if (drained) state_r <= best_v_r ? ST_EMIT : ST_FIN;
        end
        ST_EMIT: begin
          if (!pend_v_r || out_free) begin
            if (pend_v_r) out_valid_r <= 1'b1;
            pend_v_r           <= 1'b1;
            done_r[best_idx_r] <= 1'b1;
            emitted_r          <= emitted_inc;
            issue_r            <= '0;
            state_r            <= (emitted_inc == limit) ? ST_FIN : ST_SUPP;
          end
        end
        ST_SUPP: begin
          if (drained) begin
            issue_r  <= '0;
            best_v_r <= 1'b0;
            state_r  <= ST_FIND;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            pend_v_r    <= 1'b0;
            cnt_r       <= '0;
            ovf_r       <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !q_item.is_end && (cnt_r != cbs_pkg::CNT_W'(cbs_pkg::MAX_BOXES))) begin
      geom_mem[cnt_r[cbs_pkg::IDX_W-1:0]] <= {q_item.x, q_item.y, q_item.w, q_item.h};
      sc_mem[cnt_r[cbs_pkg::IDX_W-1:0]]   <= {q_item.score, q_item.cls};
    end
    rd_geom_r <= geom_mem[issue_r[cbs_pkg::IDX_W-1:0]];
    rd_sc_r   <= sc_mem[issue_r[cbs_pkg::IDX_W-1:0]];
    rd_idx_r  <= issue_r[cbs_pkg::IDX_W-1:0];

    if (find_hit) begin
      best_idx_r <= rd_idx_r;
      bx_r       <= rx;
      by_r       <= ry;
      bw_r       <= rw;
      bh_r       <= rh;
      bscore_r   <= rscore;
      bcls_r     <= rcls;
      barea_r    <= rd_area;
    end

    a_idx_r   <= rd_idx_r;
    iw_r      <= iw;
    ih_r      <= ih;
    a_area_r  <= rd_area;
    b_idx_r   <= a_idx_r;
    inter_r   <= iw_r * ih_r;
    b_area_r  <= a_area_r;
    c_idx_r   <= b_idx_r;
    uni_r     <= {1'b0, barea_r} + {1'b0, b_area_r} - {1'b0, inter_r};
    c_inter_r <= inter_r;
    d_idx_r   <= c_idx_r;
    rhs_r     <= uni_r * cfg.iou_thr;
    lhs_r     <= {c_inter_r, {cbs_pkg::SCORE_W{1'b0}}};
    uni_nz_r  <= (uni_r != '0);

    if ((state_r == ST_EMIT) && (!pend_v_r || out_free)) begin
      if (pend_v_r) out_r <= pend_r;
      pend_r.valid_res <= 1'b1;
      pend_r.x         <= bx_r;
      pend_r.y         <= by_r;
      pend_r.w         <= bw_r;
      pend_r.h         <= bh_r;
      pend_r.score     <= bscore_r;
      pend_r.cls       <= bcls_r;
      pend_r.last      <= 1'b0;
      pend_r.ovf       <= ovf_r;
    end
    if ((state_r == ST_FIN) && out_free) begin
      if (pend_v_r) begin
        out_r      <= pend_r;
        out_r.last <= 1'b1;
      end else begin
        out_r      <= '0;
        out_r.last <= 1'b1;
        out_r.ovf  <= ovf_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  `CBS_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= cbs_pkg::CNT_W'(cbs_pkg::MAX_BOXES))
  `CBS_ASSERT_ALWAYS(a_idle_no_pend, (state_r != ST_IDLE) || !pend_v_r)
  `CBS_ASSERT_ALWAYS(a_emit_bound, (state_r == ST_IDLE) || (emitted_r <= n_r))
  `CBS_ASSERT_NEXT(a_fin_out, (state_r == ST_FIN) && out_free, out_valid_r && out_r.last)
endmodule

// ===== rtl/class_wise_box_suppression_unit.sv =====
// Class-wise box suppression: top level joining front, queue and back end.
// Load beat: accepted while the queue has room, queued in the FIFO, then written to
// the box store once the back end is idle. Frame end: for each kept box, a select
// scan, an emit (which may wait on the output) and an overlap scan; unless the limit is
// reached, a closing select scan finds no box. New beats wait in the queue meanwhile.
// Reset (rst_n low, synchronous) clears counts, flags and registers to defaults.
`timescale 1ns / 1ps
module class_wise_box_suppression_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cbs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic [cbs_pkg::COORD_W-1:0]     in_box_x,
  input  logic [cbs_pkg::COORD_W-1:0]     in_box_y,
  input  logic [cbs_pkg::COORD_W-1:0]     in_box_w,
  input  logic [cbs_pkg::COORD_W-1:0]     in_box_h,
  input  logic [cbs_pkg::SCORE_W-1:0]     in_confidence,
  input  logic [cbs_pkg::CLASS_W-1:0]     in_class_id,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_valid_res,
  output logic [cbs_pkg::COORD_W-1:0]     out_x,
  output logic [cbs_pkg::COORD_W-1:0]     out_y,
  output logic [cbs_pkg::COORD_W-1:0]     out_w,
  output logic [cbs_pkg::COORD_W-1:0]     out_h,
  output logic [cbs_pkg::SCORE_W-1:0]     out_score,
  output logic [cbs_pkg::CLASS_W-1:0]     out_class,
  output logic                            out_last,
  output logic                            out_overflow
);
  cbs_pkg::cfg_t    cfg;
  cbs_pkg::q_item_t push_item, pop_item;
  cbs_pkg::res_t    res;
  logic             q_push, q_full, q_pop, q_valid;

  cbs_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_cmd, .in_box_x, .in_box_y, .in_box_w, .in_box_h,
    .in_confidence, .in_class_id,
    .q_full, .q_push, .q_item(push_item), .cfg
  );

  cbs_fifo u_fifo (
    .clk, .rst_n, .push(q_push), .push_item, .full(q_full),
    .pop(q_pop), .valid(q_valid), .pop_item
  );

  cbs_back u_back (
    .clk, .rst_n, .cfg, .q_valid, .q_item(pop_item), .q_pop,
    .out_valid, .out_ready, .out_res(res)
  );

  assign out_valid_res = res.valid_res;
  assign out_x         = res.x;
  assign out_y         = res.y;
  assign out_w         = res.w;
  assign out_h         = res.h;
  assign out_score     = res.score;
  assign out_class     = res.cls;
  assign out_last      = res.last;
  assign out_overflow  = res.ovf;
endmodule

// ===== test/testbench.sv =====
// Self-checking bench for class_wise_box_suppression_unit: frames of boxes, frame-end emits.
// Depends on rtl/cbs_pkg.sv and the unit RTL; predicts per-class suppression in a scoreboard.
`timescale 1ns / 1ps

class nms_scoreboard;
  // predictor copy of configuration and box store
  bit [15:0] conf_thr;
  bit [15:0] iou_thr;
  bit [6:0]  max_det;
  bit [63:0] cls_mask;
  bit [15:0] gx[64], gy[64], gw[64], gh[64], gs[64];
  bit [5:0]  gc[64];
  int        n_boxes;
  bit        ovf_seen;
  cbs_pkg::res_t pending_results[$];
  int        errors;

  function void reset_state();
    conf_thr = 16'd32768;
    iou_thr = 16'd26214;
    max_det = 7'd64;
    cls_mask = '1;
    n_boxes = 0;
    ovf_seen = 0;
    pending_results.delete();
    errors = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [63:0] val);
    case (idx)
      cbs_pkg::CFG_CONF_THR: conf_thr = val[15:0];
      cbs_pkg::CFG_IOU_THR:  iou_thr = val[15:0];
      cbs_pkg::CFG_MAX_DET:  max_det = val[6:0];
      cbs_pkg::CFG_CLS_MASK: cls_mask = val;
      default: ;
    endcase
  endfunction

  function bit overlaps(int a, int b);
    bit [16:0] x1, y1, x2, y2, ax2, bx2, ay2, by2;
    bit [33:0] inter, ua, ub, uni;
    bit [63:0] lhs, rhs;
    x1 = (gx[a] > gx[b]) ? gx[a] : gx[b];
    y1 = (gy[a] > gy[b]) ? gy[a] : gy[b];
    ax2 = gx[a] + gw[a]; bx2 = gx[b] + gw[b];
    ay2 = gy[a] + gh[a]; by2 = gy[b] + gh[b];
    x2 = (ax2 < bx2) ? ax2 : bx2;
    y2 = (ay2 < by2) ? ay2 : by2;
    inter = ((x2 > x1) ? x2 - x1 : 0) * ((y2 > y1) ? y2 - y1 : 0);
    ua = gw[a] * gh[a];
    ub = gw[b] * gh[b];
    uni = ua + ub - inter;
    if (uni == 0) return 0;
    lhs = {30'd0, inter} << 16;
    rhs = 64'(uni) * 64'(iou_thr);
    return lhs > rhs;
  endfunction

  function void note_input(cbs_pkg::q_item_t it);
    int order[64];
    bit supp[64];
    int k, lim, emitted;
    cbs_pkg::res_t r;
    if (it.is_end == cbs_pkg::CMD_LOAD) begin
      if (it.score < conf_thr || !cls_mask[it.cls]) return;
      if (n_boxes >= 64) begin
        ovf_seen = 1;
        return;
      end
      gx[n_boxes] = it.x; gy[n_boxes] = it.y; gw[n_boxes] = it.w; gh[n_boxes] = it.h;
      gs[n_boxes] = it.score; gc[n_boxes] = it.cls;
      n_boxes++;
      return;
    end
    for (int i = 0; i < n_boxes; i++) begin
      k = i;
      while (k > 0 && gs[order[k-1]] < gs[i]) begin
        order[k] = order[k-1];
        k--;
      end
      order[k] = i;
      supp[i] = 0;
    end
    lim = (max_det == 0 || max_det > n_boxes) ? n_boxes : max_det;
    emitted = 0;
    for (int i = 0; i < n_boxes; i++) begin
      if (supp[order[i]]) continue;
      for (int j = i + 1; j < n_boxes; j++)
        if (!supp[order[j]] && gc[order[j]] == gc[order[i]] && overlaps(order[i], order[j]))
          supp[order[j]] = 1;
      if (emitted < lim) begin
        r = '{1'b1, gx[order[i]], gy[order[i]], gw[order[i]], gh[order[i]],
              gs[order[i]], gc[order[i]], 1'b0, ovf_seen};
        pending_results = {pending_results, r};
        emitted++;
      end
    end
    if (emitted == 0) begin
      r = '0;
      r.ovf = ovf_seen;
      pending_results = {pending_results, r};
    end
    pending_results[$].last = 1;
    n_boxes = 0;
    ovf_seen = 0;
  endfunction

  function void check_result(cbs_pkg::res_t got);
    cbs_pkg::res_t want;
    if (pending_results.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result beat %p", got);
      return;
    end
    want = pending_results.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
    end
  endfunction
endclass

module testbench;
  localparam int WATCHDOG_LIMIT = 200000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [cbs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cbs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_ready;
  logic in_cmd = 0;
  logic [15:0] in_box_x = 0, in_box_y = 0, in_box_w = 0, in_box_h = 0, in_confidence = 0;
  logic [5:0] in_class_id = 0;
  logic out_valid, out_ready = 0;
  logic out_valid_res, out_last, out_overflow;
  logic [15:0] out_x, out_y, out_w, out_h, out_score;
  logic [5:0] out_class;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 0;
  int quiet_cycles = 0;
  nms_scoreboard board;

  class_wise_box_suppression_unit dut (.*);

  always #5 clk = ~clk;

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (out_valid && out_ready)
      board.check_result('{out_valid_res, out_x, out_y, out_w, out_h, out_score,
                           out_class, out_last, out_overflow});
    out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // valid stays up after an accepted beat only when the next beat follows at once
  task automatic send_beat(bit cmd, bit [15:0] x, y, w, h, s, bit [5:0] c);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    in_valid <= 1;
    in_cmd <= cmd;
    in_box_x <= x; in_box_y <= y; in_box_w <= w; in_box_h <= h;
    in_confidence <= s; in_class_id <= c;
    do @(posedge clk); while (!in_ready);
    board.note_input('{cmd, x, y, w, h, s, c});
  endtask

  task automatic send_box(bit [15:0] x, y, w, h, s, bit [5:0] c);
    send_beat(cbs_pkg::CMD_LOAD, x, y, w, h, s, c);
  endtask

  task automatic end_frame();
    send_beat(cbs_pkg::CMD_END, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 6'($urandom));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.write_reg(idx, val);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // clustered boxes so suppression actually fires
  task automatic random_frame(int nbox);
    bit [15:0] bx, by;
    bx = 16'($urandom_range(2000));
    by = 16'($urandom_range(2000));
    for (int i = 0; i < nbox; i++) begin
      if ($urandom_range(9) == 0)
        send_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 6'($urandom));
      else
        send_box(16'(bx + $urandom_range(64)), 16'(by + $urandom_range(64)),
                 16'($urandom_range(40, 300)), 16'($urandom_range(40, 300)),
                 ($urandom_range(3) == 0) ? 16'($urandom_range(4)) * 16'h4000
                                          : 16'($urandom),
                 6'($urandom_range(3)));
    end
    end_frame();
  endtask

  initial begin
    int sent;
    board = new();
    board.reset_state();
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty frame, extremes, duplicates, zero area, ties
    end_frame();
    send_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63);
    send_box(0, 0, 0, 0, 16'h8000, 6'd0);
    send_box(0, 0, 0, 0, 16'h8000, 6'd0);
    send_box(100, 100, 50, 50, 16'h7FFF, 6'd1);
    send_box(100, 100, 50, 50, 16'h9000, 6'd1);
    send_box(100, 100, 50, 50, 16'h9000, 6'd2);
    send_box(110, 105, 50, 50, 16'hA000, 6'd1);
    end_frame();
    drain();
    write_reg(cbs_pkg::CFG_CONF_THR, 64'h0);
    write_reg(cbs_pkg::CFG_IOU_THR, 64'hFFFF);
    write_reg(cbs_pkg::CFG_MAX_DET, 64'h0);
    write_reg(cbs_pkg::CFG_CLS_MASK, 64'h5555_5555_5555_5555);
    send_box(0, 0, 10, 10, 0, 6'd0);
    send_box(0, 0, 10, 10, 0, 6'd1);
    send_box(0, 0, 10, 10, 16'hFFFF, 6'd2);
    end_frame();
    end_frame();
    drain();
    write_reg(cbs_pkg::CFG_IOU_THR, 64'h0);
    write_reg(cbs_pkg::CFG_MAX_DET, 64'h1);
    write_reg(cbs_pkg::CFG_CLS_MASK, '1);
    send_box(0, 0, 10, 10, 5, 6'd3);
    send_box(50, 50, 10, 10, 9, 6'd3);
    end_frame();
    drain();
    // overflow: 66 boxes into a 64-entry store
    write_reg(cbs_pkg::CFG_MAX_DET, 64'd64);
    for (int i = 0; i < 66; i++)
      send_box(16'(i * 40), 16'(i) * 16'd40, 20, 20, 16'($urandom), 6'(i));
    end_frame();
    drain();

    // random phases with varied registers
    sent = 0;
    for (int ph = 0; sent < 365; ph++) begin
      case (ph % 5)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 87; end
        3: begin sender_idle_pct = 28; recv_stall_pct = 28; end
        default: begin sender_idle_pct = $urandom_range(50); recv_stall_pct = 0; end
      endcase
      write_reg(cbs_pkg::CFG_CONF_THR,
                (ph % 3 == 0) ? 64'hFFFF : 64'($urandom_range(16'h6000)));
      write_reg(cbs_pkg::CFG_IOU_THR, (ph % 4 == 0) ? 64'h0 : 64'($urandom));
      write_reg(cbs_pkg::CFG_MAX_DET, (ph % 6 == 1) ? 64'd127 : 64'($urandom_range(64)));
      write_reg(cbs_pkg::CFG_CLS_MASK, (ph % 2) ? '1 : {$urandom, $urandom});
      if (ph == 2) begin
        // long receiver hold-off while frames keep coming
        fork
          begin
            recv_hold = 1;
            repeat (3000) @(posedge clk);
            recv_hold = 0;
          end
        join_none
      end
      for (int f = 0; f < 4; f++) begin
        int nb;
        nb = ($urandom_range(9) == 0) ? $urandom_range(40, 64) : $urandom_range(0, 12);
        random_frame(nb);
        sent += nb + 1;
      end
      drain();
    end

    recv_stall_pct = 0;
    drain();
    if (board.errors == 0 && board.pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
